/* hdl/cidr_acl_pkg.sv */
// ----------------------------------------------------------------------------
// cidr_acl_pkg
// Shared types, widths and helpers for the IPv4 CIDR access control list.
// ----------------------------------------------------------------------------
package cidr_acl_pkg;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned PLEN_W       = 6;
  localparam int unsigned RULE_SLOTS   = 8;
  localparam int unsigned IDX_W        = 3;
  localparam int unsigned RULE_W       = 40;
  localparam int unsigned NUM_RULES_DEF = 8;
  localparam logic [PLEN_W-1:0] FULL_PREFIX = PLEN_W'(ADDR_W);

  // One rule as laid out in its configuration register.
  typedef struct packed {
    logic              valid;
    logic              deny;
    logic [PLEN_W-1:0] plen;
    logic [ADDR_W-1:0] network;
  } rule_t;

  // Outcome of one lookup.
  typedef struct packed {
    logic             allowed;
    logic             matched;
    logic [IDX_W-1:0] rule_index;
  } result_t;

  // Network mask for a prefix length; lengths above 32 saturate to 32 and a
  // length of zero gives an empty mask that matches every address.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [PLEN_W-1:0] sat;
    sat = (plen > FULL_PREFIX) ? FULL_PREFIX : plen;
    return ~({ADDR_W{1'b1}} >> sat);
  endfunction

endpackage

/* hdl/cidr_acl_if.sv */
// ----------------------------------------------------------------------------
// cidr_acl_if
// Valid/ready channels for client addresses and lookup results.
// ----------------------------------------------------------------------------
interface cidr_acl_in_if import cidr_acl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] client_ip;

  modport source (output valid, output client_ip, input ready);
  modport sink   (input valid, input client_ip, output ready);
endinterface

interface cidr_acl_out_if import cidr_acl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             allowed;
  logic             matched;
  logic [IDX_W-1:0] rule_index;

  modport source (output valid, output allowed, output matched, output rule_index,
                  input ready);
  modport sink   (input valid, input allowed, input matched, input rule_index,
                  output ready);
endinterface

/* hdl/cidr_acl_rule_regs.sv */
// ----------------------------------------------------------------------------
// cidr_acl_rule_regs
// Configuration registers holding the ordered rule list.
// ----------------------------------------------------------------------------
module cidr_acl_rule_regs import cidr_acl_pkg::*; #(
  parameter int unsigned NUM_RULES = NUM_RULES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [RULE_W-1:0] cfg_wdata_i,
  output rule_t             rules_o [NUM_RULES]
);

  rule_t rules_q [NUM_RULES];

  // Rules beyond NUM_RULES are never consulted, so they are not stored.
  for (genvar g = 0; g < NUM_RULES; g++) begin : g_rule
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rules_q[g] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == IDX_W'(g))) begin
        rules_q[g] <= rule_t'(cfg_wdata_i);
      end
    end
    assign rules_o[g] = rules_q[g];
  end

endmodule

/* hdl/cidr_acl_lookup.sv */
// ----------------------------------------------------------------------------
// cidr_acl_lookup
// Masked compare of one address against every rule and first-match pick.
// ----------------------------------------------------------------------------
module cidr_acl_lookup import cidr_acl_pkg::*; #(
  parameter int unsigned NUM_RULES = NUM_RULES_DEF
) (
  input  logic [ADDR_W-1:0] client_ip_i,
  input  rule_t             rules_i [NUM_RULES],
  output result_t           result_o
);

  logic [NUM_RULES-1:0] hit;

  for (genvar g = 0; g < NUM_RULES; g++) begin : g_cmp
    logic [ADDR_W-1:0] mask;
    assign mask   = prefix_mask(rules_i[g].plen);
    assign hit[g] = rules_i[g].valid &&
                    ((client_ip_i & mask) == (rules_i[g].network & mask));
  end

  // Walk from lowest to highest priority so the lowest-numbered hit wins.
  always_comb begin
    result_o = '{allowed: 1'b1, matched: 1'b0, rule_index: '0};
    for (int i = NUM_RULES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        result_o.allowed    = ~rules_i[i].deny;
        result_o.matched    = 1'b1;
        result_o.rule_index = IDX_W'(i);
      end
    end
  end

endmodule

/* hdl/ipv4_cidr_acl_match.sv */
// ----------------------------------------------------------------------------
// ipv4_cidr_acl_match
// First-match IPv4 CIDR access control list with valid/ready channels.
// ----------------------------------------------------------------------------
// An address is registered in the input register when it transfers; its result is
// loaded into the result register once that register can load, and is offered until taken.
// Throughput: one address per cycle while results are taken, as the rule compare is
// combinational between the input register and the result register.
// Reset: rst_ni clears all rules to invalid and empties both stages; with no
// valid rule every address is allowed.
module ipv4_cidr_acl_match import cidr_acl_pkg::*; #(
  parameter int unsigned NUM_RULES = NUM_RULES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [IDX_W-1:0]      cfg_idx_i,
  input  logic [RULE_W-1:0]     cfg_wdata_i,
  cidr_acl_in_if.sink           in_i,
  cidr_acl_out_if.source        out_o
);

  // Rule storage. Configuration is to be changed only while the pipeline is empty, so
  // the lookup sees a stable rule set; the block itself does not enforce this.
  rule_t rules [NUM_RULES];

  cidr_acl_rule_regs #(
    .NUM_RULES (NUM_RULES)
  ) u_rule_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rules_o     (rules)
  );

  // Input stage: the address is registered on each transfer.
  logic              in_valid_q, in_valid_d;
  logic [ADDR_W-1:0] ip_q;

  // Result stage: the lookup outcome waits here until the sink takes it.
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;

  logic              out_load;
  logic              in_ready;

  // The result register may load whenever it is empty or being emptied this
  // cycle; the input register may load whenever it is empty or its item moves on.
  // This lets an address follow in every cycle while results are taken; while a
  // result is stalled, the input register takes an address only if it is empty.
  assign out_load = !out_valid_q || out_o.ready;
  assign in_ready = !in_valid_q || out_load;

  assign in_i.ready = in_ready;

  cidr_acl_lookup #(
    .NUM_RULES (NUM_RULES)
  ) u_lookup (
    .client_ip_i (ip_q),
    .rules_i     (rules),
    .result_o    (res_d)
  );

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (in_ready) begin
      in_valid_d = in_i.valid;
    end
    if (out_load) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      ip_q <= in_i.client_ip;
    end
    if (out_load && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.allowed    = res_q.allowed;
  assign out_o.matched    = res_q.matched;
  assign out_o.rule_index = res_q.rule_index;

endmodule

/* hdl/cidr_acl_checker.sv */
// ----------------------------------------------------------------------------
// cidr_acl_checker
// Port-level checks for the access control list, bound to the top level.
// ----------------------------------------------------------------------------
module cidr_acl_checker import cidr_acl_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             allowed_i,
  input logic             matched_i,
  input logic [IDX_W-1:0] rule_index_i
);

  // A result with no matching rule is an allow with index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !matched_i) |-> (allowed_i && (rule_index_i == '0)))
    else $error("unmatched result must allow with index zero");

  // A newly raised result must trace back to an address transfer into the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without a matching address transfer");

  // With the result register empty the block must take a new address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while no result was pending");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("stalled result was withdrawn");

endmodule

bind ipv4_cidr_acl_match cidr_acl_checker u_cidr_acl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .allowed_i    (out_o.allowed),
  .matched_i    (out_o.matched),
  .rule_index_i (out_o.rule_index)
);
